// ----- rtl/sorted_timestamp_insert_table_macros.svh -----
// Assertion macros shared by the checker of the sorted timestamp table.
`ifndef SORTED_TIMESTAMP_INSERT_TABLE_MACROS_SVH
`define SORTED_TIMESTAMP_INSERT_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define STIT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted timestamp table: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define STIT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted timestamp table: next-cycle check failed");

`endif

// ----- rtl/stit_pkg.sv -----
// Types and constants of the sorted timestamp table.
package stit_pkg;

  localparam int ENTRIES = 64;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int FLD_W   = 7;
  localparam int TAG_W   = 16;

  localparam logic [FLD_W-1:0] MONTH_MAX = 7'd12;
  localparam logic [FLD_W-1:0] DAY_MAX   = 7'd31;

  typedef enum logic [2:0] {
    ST_STORED    = 3'd0,
    ST_BAD_MONTH = 3'd1,
    ST_BAD_DAY   = 3'd2,
    ST_FULL      = 3'd3,
    ST_LISTED    = 3'd4,
    ST_EMPTY     = 3'd5
  } status_t;

  // Command broadcast to every cell of the row.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SHIFT_UP
  } cell_op_t;

  // Sort key, most significant part first, so the packed value compares in order.
  typedef struct packed {
    logic [FLD_W-1:0] month;
    logic [FLD_W-1:0] day;
    logic [FLD_W-1:0] hour;
    logic [FLD_W-1:0] minute;
    logic [FLD_W-1:0] second;
  } key_t;

  typedef struct packed {
    key_t             key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   item;
  } cell_cmd_t;

  typedef struct packed {
    logic [FLD_W-1:0] month;
    logic [FLD_W-1:0] day;
    logic [FLD_W-1:0] hour;
    logic [FLD_W-1:0] minute;
    logic [FLD_W-1:0] second;
    logic [TAG_W-1:0] message_tag;
  } request_t;

  typedef struct packed {
    status_t          status;
    logic [FLD_W-1:0] out_month;
    logic [FLD_W-1:0] out_day;
    logic [FLD_W-1:0] out_hour;
    logic [FLD_W-1:0] out_minute;
    logic [FLD_W-1:0] out_second;
    logic [TAG_W-1:0] out_tag;
    logic             last;
  } result_t;

endpackage

// ----- rtl/stit_cell.sv -----
// One cell of the sorted row: holds one entry, compares it and shifts.
module stit_cell (
  input  logic               clk,
  input  stit_pkg::cell_cmd_t cmd,
  input  logic               occupied,
  input  logic               ge_prev,
  input  stit_pkg::entry_t   prev_entry,
  input  stit_pkg::entry_t   next_entry,
  output logic               ge,
  output stit_pkg::entry_t   entry
);

  // An empty cell counts as larger, so the flags stay monotone along the row.
  assign ge = !occupied || (entry.key >= cmd.item.key);

  // Insert at the first larger-or-equal cell, push later cells down by one,
  // or move every entry one place toward the head during a listing.
  always_ff @(posedge clk) begin
    case (cmd.op)
      stit_pkg::OP_INSERT: begin
        if (ge_prev) begin
          entry <= prev_entry;
        end else if (ge) begin
          entry <= cmd.item;
        end
      end
      stit_pkg::OP_SHIFT_UP: begin
        entry <= next_entry;
      end
      default: begin
        entry <= entry;
      end
    endcase
  end

endmodule

// ----- rtl/sorted_timestamp_insert_table.sv -----
// Sorted timestamp table: a row of cells kept in key order, with request
// and result registers on its two sides.
//
// A request is taken into a request register, then checked and either
// rejected or inserted into the row of cells in one compare-and-shift step;
// only then is the next request taken. A listing request with n stored
// entries yields n results, one per cycle unless result_stall holds them, as
// the row shifts toward its head cell; with an empty table it yields one
// result. While a listing runs, the next request is already taken into the
// request register. The result register holds a result while result_stall
// is high, and the row advances only when that register can take a new
// result. Store contents after reset are never read before they are written,
// since only cells below the entry count take part.
module sorted_timestamp_insert_table (
  input  logic               clk,
  input  logic               rst,
  input  logic               request_valid,
  output logic               request_stall,
  input  stit_pkg::request_t request,
  output logic               result_valid,
  input  logic               result_stall,
  output stit_pkg::result_t  result
);

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_t;

  state_t                      state;
  logic [stit_pkg::CNT_W-1:0]  count;
  logic [stit_pkg::CNT_W-1:0]  remaining;
  logic                        pend_valid;
  stit_pkg::request_t          pend;

  stit_pkg::cell_cmd_t         cmd;
  stit_pkg::entry_t            entry [stit_pkg::ENTRIES];
  logic [stit_pkg::ENTRIES-1:0] ge;
  stit_pkg::result_t           result_next;

  logic out_free;
  logic go;
  logic store;
  logic is_list;
  logic bad_month;
  logic bad_day;
  logic full;

  assign request_stall = pend_valid;
  assign out_free      = !result_valid || !result_stall;
  assign go            = pend_valid && out_free && (state == S_IDLE);
  assign is_list       = (pend.month == '0) || (pend.day == '0);
  assign bad_month     = pend.month > stit_pkg::MONTH_MAX;
  assign bad_day       = pend.day > stit_pkg::DAY_MAX;
  assign full          = count == stit_pkg::CNT_W'(stit_pkg::ENTRIES);
  assign store         = go && !is_list && !bad_month && !bad_day && !full;

  // Command to the row: insert a valid entry, or shift during a listing.
  always_comb begin
    cmd.op                = stit_pkg::OP_HOLD;
    cmd.item.key.month    = pend.month;
    cmd.item.key.day      = pend.day;
    cmd.item.key.hour     = pend.hour;
    cmd.item.key.minute   = pend.minute;
    cmd.item.key.second   = pend.second;
    cmd.item.tag          = pend.message_tag;
    if (store) begin
      cmd.op = stit_pkg::OP_INSERT;
    end else if ((state == S_LIST) && out_free) begin
      cmd.op = stit_pkg::OP_SHIFT_UP;
    end
  end

  // Row of cells; each cell sees its neighbors on both sides.
  for (genvar i = 0; i < stit_pkg::ENTRIES; i++) begin : g_cell
    logic             ge_prev;
    stit_pkg::entry_t prev_entry;
    stit_pkg::entry_t next_entry;

    if (i == 0) begin : g_head
      assign ge_prev    = 1'b0;
      assign prev_entry = entry[i];
    end else begin : g_body
      assign ge_prev    = ge[i-1];
      assign prev_entry = entry[i-1];
    end

    if (i == stit_pkg::ENTRIES - 1) begin : g_tail
      assign next_entry = entry[i];
    end else begin : g_inner
      assign next_entry = entry[i+1];
    end

    stit_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .occupied   (stit_pkg::CNT_W'(i) < count),
      .ge_prev    (ge_prev),
      .prev_entry (prev_entry),
      .next_entry (next_entry),
      .ge         (ge[i]),
      .entry      (entry[i])
    );
  end

  // Next result: the head entry during a listing, else the status of the request.
  always_comb begin
    result_next      = '0;
    result_next.last = 1'b1;
    if (state == S_LIST) begin
      result_next.status     = stit_pkg::ST_LISTED;
      result_next.out_month  = entry[0].key.month;
      result_next.out_day    = entry[0].key.day;
      result_next.out_hour   = entry[0].key.hour;
      result_next.out_minute = entry[0].key.minute;
      result_next.out_second = entry[0].key.second;
      result_next.out_tag    = entry[0].tag;
      result_next.last       = remaining == stit_pkg::CNT_W'(1);
    end else if (is_list) begin
      result_next.status = stit_pkg::ST_EMPTY;
    end else if (bad_month) begin
      result_next.status = stit_pkg::ST_BAD_MONTH;
    end else if (bad_day) begin
      result_next.status = stit_pkg::ST_BAD_DAY;
    end else if (full) begin
      result_next.status = stit_pkg::ST_FULL;
    end else begin
      result_next.status = stit_pkg::ST_STORED;
    end
  end

  // Payload of the request register.
  always_ff @(posedge clk) begin
    if (request_valid && !request_stall) begin
      pend <= request;
    end
  end

  // Control state, entry count and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      remaining    <= '0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (go) begin
            pend_valid <= 1'b0;
            if (is_list && (count != '0)) begin
              // Results come from the head cell during the listing.
              result_valid <= 1'b0;
              remaining    <= count;
              state        <= S_LIST;
            end else begin
              result_valid <= 1'b1;
              result       <= result_next;
              if (store) begin
                count <= count + 1'b1;
              end
            end
          end else begin
            if (request_valid && !request_stall) begin
              pend_valid <= 1'b1;
            end
            if (result_valid && !result_stall) begin
              result_valid <= 1'b0;
            end
          end
        end
        S_LIST: begin
          if (request_valid && !request_stall) begin
            pend_valid <= 1'b1;
          end
          if (out_free) begin
            result_valid <= 1'b1;
            result       <= result_next;
            remaining    <= remaining - 1'b1;
            if (remaining == stit_pkg::CNT_W'(1)) begin
              count <= '0;
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/stit_checker.sv -----
// Port-level checker of the sorted timestamp table and its bind.
`include "sorted_timestamp_insert_table_macros.svh"

module stit_checker (
  input logic               clk,
  input logic               rst,
  input logic               request_valid,
  input logic               request_stall,
  input logic               result_valid,
  input logic               result_stall,
  input stit_pkg::result_t  result
);

  logic no_entry;

  assign no_entry = (result.out_month == '0) && (result.out_day == '0) &&
                    (result.out_hour == '0) && (result.out_minute == '0) &&
                    (result.out_second == '0) && (result.out_tag == '0);

  // A stalled result stays in place.
  `STIT_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
    result_valid && $stable(result))

  // Results that are not listed entries carry no entry and end their request.
  `STIT_ASSERT_NOW(a_status_only, result_valid && (result.status != stit_pkg::ST_LISTED),
    no_entry && result.last)

  // An accepted request fills the request register, so the next one waits.
  `STIT_ASSERT_NEXT(a_one_pending, request_valid && !request_stall, request_stall)

  // A listing entry always carries a valid, nonzero month and day.
  `STIT_ASSERT_NOW(a_listed_key, result_valid && (result.status == stit_pkg::ST_LISTED),
    (result.out_month != '0) && (result.out_day != '0) &&
    (result.out_month <= stit_pkg::MONTH_MAX) && (result.out_day <= stit_pkg::DAY_MAX))

endmodule

bind sorted_timestamp_insert_table stit_checker u_stit_checker (.*);
